[hdl/srce_pkg.sv]
// shared types and constants of the swapped route cost evaluator
// no dependencies
package srce_pkg;

    localparam int ACC_W = 21;
    localparam int LEN_W = 5;
    localparam int TASK_W = 4;
    localparam int IDX_W = 8;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_ELEM  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic [1:0] REG_TASK_COUNT  = 2'd0;
    localparam logic [1:0] REG_REMOVE_TASK = 2'd1;
    localparam logic [1:0] REG_INSERT_TASK = 2'd2;
    localparam logic [1:0] REG_INSERT_POS  = 2'd3;

    typedef struct packed {
        logic valid;
        logic use_data;
        logic fin;
        logic err;
    } lookup_t;

endpackage

[hdl/swapped_route_cost_evaluator.sv]
// throughput: one word per cycle unless a finished result is stalled at the output;
// an element that takes the inserted task, or a kept ending element followed by the
// inserted task, holds the input for a second lookup on the one table read port
// reset (synchronous, active low): path state, accumulator and output valid clear, registers
// go to defaults; cost table contents stay undefined until written, no clearing pass
module swapped_route_cost_evaluator #(
    parameter int MAX_TASKS = 15,
    parameter int COST_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_func,
    input  logic [7:0]                        s_cost_index,
    input  logic [15:0]                       s_cost_value,
    input  logic [3:0]                        s_path_task,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [srce_pkg::ACC_W-1:0]        m_total_cost,
    output logic                              m_position_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [4:0]                        cfg_data
);

    localparam int TABLE_DEPTH = (MAX_TASKS + 1) * (MAX_TASKS + 1);

    function automatic logic [srce_pkg::IDX_W-1:0] idx_of(
        input logic [3:0] from, input logic [4:0] stride, input logic [3:0] to);
        logic [8:0] prod;
        prod = 9'(from) * 9'(stride);
        return srce_pkg::IDX_W'(prod + 9'(to));
    endfunction

    function automatic logic [4:0] len_inc(input logic [4:0] len);
        return (len == 5'd31) ? len : len + 5'd1;
    endfunction

    // configuration
    logic [3:0] tc_reg;
    logic [4:0] rm_reg;
    logic [4:0] ins_reg;
    logic [4:0] pos_reg;

    // path state
    logic [3:0] prev_reg, prev_next;
    logic [4:0] len_reg, len_next;
    logic       rdone_reg, rdone_next;
    logic       idone_reg, idone_next;

    // second lookup and stage one
    logic                          pend_reg, pend_next;
    logic [srce_pkg::IDX_W-1:0]    addr2_reg, addr2_next;
    logic                          fin2_reg, fin2_next;
    logic                          err2_reg, err2_next;
    srce_pkg::lookup_t             s1_reg, s1_next;
    logic [srce_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                          m_valid_reg, m_valid_next;
    logic [srce_pkg::ACC_W-1:0]    total_reg;
    logic                          perr_reg;

    logic       ins_act, rm_act, rm_hit, ins_now;
    logic [4:0] stride;
    logic [3:0] from_a, from_b, from_c, prev_a, prev_b, e_prev;
    logic [4:0] len_a, len_b, e_len;
    logic       e_idone, end_pend, end_ok;
    logic [srce_pkg::IDX_W-1:0] addr_a, addr_b, addr_c, addr1, addr2, rd_idx;
    logic       look1, look2, fin, err;
    logic       acc_in, pend_go, stall1, s1_go, rd_en, wr_en;
    logic [COST_BITS-1:0]       rd_data;
    logic [srce_pkg::ACC_W-1:0] sum;

    assign ins_act = !ins_reg[4];
    assign rm_act  = !rm_reg[4];
    assign stride  = {1'b0, tc_reg} + 5'd1;

    // element decode
    always_comb begin
        rm_hit  = rm_act && !rdone_reg && (s_path_task == rm_reg[3:0]);
        ins_now = !rm_hit && ins_act && !idone_reg && (pos_reg == len_reg);
        from_a  = (len_reg != 5'd0) ? prev_reg : 4'd0;
        addr_a  = idx_of(from_a, stride, ins_reg[3:0]);
        len_a   = ins_now ? len_inc(len_reg) : len_reg;
        prev_a  = ins_now ? ins_reg[3:0] : prev_reg;
        from_b  = (len_a != 5'd0) ? prev_a : 4'd0;
        addr_b  = idx_of(from_b, stride, s_path_task);
        len_b   = rm_hit ? len_a : len_inc(len_a);
        prev_b  = rm_hit ? prev_a : s_path_task;
        if (s_func == srce_pkg::FUNC_ELEM) begin
            e_len   = len_b;
            e_prev  = prev_b;
            e_idone = idone_reg | ins_now;
        end else begin
            e_len   = len_reg;
            e_prev  = prev_reg;
            e_idone = idone_reg;
        end
        end_pend = ins_act && !e_idone;
        end_ok   = (e_len == pos_reg);
        from_c   = (e_len != 5'd0) ? e_prev : 4'd0;
        addr_c   = idx_of(from_c, stride, ins_reg[3:0]);
    end

    // lookup plan for one word
    always_comb begin
        look1 = 1'b0;
        look2 = 1'b0;
        fin   = 1'b0;
        err   = 1'b0;
        addr1 = addr_b;
        addr2 = addr_c;
        wr_en = 1'b0;
        unique case (s_func)
            srce_pkg::FUNC_WRITE: begin
                wr_en = 1'b1;
            end
            srce_pkg::FUNC_ELEM: begin
                fin = s_last;
                if (ins_now) begin
                    look1 = 1'b1;
                    look2 = 1'b1;
                    addr1 = addr_a;
                    addr2 = addr_b;
                end else if (!rm_hit) begin
                    look1 = 1'b1;
                    if (s_last && end_pend && end_ok) begin
                        look2 = 1'b1;
                    end else begin
                        err = s_last && end_pend;
                    end
                end else if (s_last && end_pend && end_ok) begin
                    look1 = 1'b1;
                    addr1 = addr_c;
                end else begin
                    err = s_last && end_pend;
                end
            end
            srce_pkg::FUNC_END: begin
                fin = 1'b1;
                if (end_pend && end_ok) begin
                    look1 = 1'b1;
                    addr1 = addr_c;
                end else begin
                    err = end_pend;
                end
            end
            default: begin
            end
        endcase
    end

    assign stall1  = s1_reg.valid && s1_reg.fin && m_valid_reg && !m_ready;
    assign s_ready = !pend_reg && !stall1;
    assign acc_in  = s_valid && s_ready;
    assign pend_go = pend_reg && !stall1;
    assign s1_go   = s1_reg.valid && !stall1;
    assign rd_en   = pend_go || (acc_in && look1);
    assign rd_idx  = pend_go ? addr2_reg : addr1;

    // issue and path state
    always_comb begin
        prev_next  = prev_reg;
        len_next   = len_reg;
        rdone_next = rdone_reg;
        idone_next = idone_reg;
        pend_next  = pend_reg;
        addr2_next = addr2_reg;
        fin2_next  = fin2_reg;
        err2_next  = err2_reg;
        s1_next    = s1_go ? '0 : s1_reg;
        if (pend_go) begin
            pend_next = 1'b0;
            s1_next   = '{valid: 1'b1, use_data: 1'b1, fin: fin2_reg, err: err2_reg};
        end else if (acc_in) begin
            if (look1) begin
                s1_next = '{valid: 1'b1, use_data: 1'b1, fin: fin && !look2,
                            err: err && !look2};
            end else if (fin) begin
                s1_next = '{valid: 1'b1, use_data: 1'b0, fin: 1'b1, err: err};
            end
            if (look2) begin
                pend_next  = 1'b1;
                addr2_next = addr2;
                fin2_next  = fin;
                err2_next  = err;
            end
            if (fin) begin
                prev_next  = 4'd0;
                len_next   = 5'd0;
                rdone_next = 1'b0;
                idone_next = 1'b0;
            end else if (s_func == srce_pkg::FUNC_ELEM) begin
                prev_next  = prev_b;
                len_next   = len_b;
                rdone_next = rdone_reg | rm_hit;
                idone_next = idone_reg | ins_now;
            end
        end
    end

    // accumulate and present result
    assign sum = srce_pkg::ACC_W'(acc_reg +
                 (s1_reg.use_data ? srce_pkg::ACC_W'(rd_data) : srce_pkg::ACC_W'(0)));

    always_comb begin
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (s1_go) begin
            if (s1_reg.fin) begin
                acc_next     = '0;
                m_valid_next = 1'b1;
            end else begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg      <= 4'd15;
            rm_reg      <= 5'h1f;
            ins_reg     <= 5'h1f;
            pos_reg     <= 5'd0;
            prev_reg    <= 4'd0;
            len_reg     <= 5'd0;
            rdone_reg   <= 1'b0;
            idone_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            s1_reg      <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    srce_pkg::REG_TASK_COUNT:  tc_reg  <= cfg_data[3:0];
                    srce_pkg::REG_REMOVE_TASK: rm_reg  <= cfg_data;
                    srce_pkg::REG_INSERT_TASK: ins_reg <= cfg_data;
                    srce_pkg::REG_INSERT_POS:  pos_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            prev_reg    <= prev_next;
            len_reg     <= len_next;
            rdone_reg   <= rdone_next;
            idone_reg   <= idone_next;
            pend_reg    <= pend_next;
            s1_reg      <= s1_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr2_reg <= addr2_next;
        fin2_reg  <= fin2_next;
        err2_reg  <= err2_next;
        if (s1_go && s1_reg.fin) begin
            total_reg <= s1_reg.err ? '0 : sum;
            perr_reg  <= s1_reg.err;
        end
    end

    srce_cost_table #(
        .DEPTH     (TABLE_DEPTH),
        .COST_BITS (COST_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (acc_in && wr_en),
        .wr_idx  (s_cost_index),
        .wr_data (s_cost_value),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_total_cost     = total_reg;
    assign m_position_error = perr_reg;

endmodule

[hdl/srce_cost_table.sv]
// cost table: synchronous ram with one write port and one read port, registered read
// out of range writes are dropped and out of range reads return zero
// depends on srce_pkg
module srce_cost_table #(
    parameter int DEPTH     = 256,
    parameter int COST_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [srce_pkg::IDX_W-1:0]   wr_idx,
    input  logic [15:0]                  wr_data,
    input  logic                         rd_en,
    input  logic [srce_pkg::IDX_W-1:0]   rd_idx,
    output logic [COST_BITS-1:0]         rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COST_BITS-1:0] mem [DEPTH];
    logic [COST_BITS-1:0] q_reg;
    logic                 hit_reg;
    logic                 wr_ok;
    logic                 rd_ok;

    assign wr_ok = 32'(wr_idx) < DEPTH;
    assign rd_ok = 32'(rd_idx) < DEPTH;

    always_ff @(posedge aclk) begin
        if (wr_en && wr_ok) begin
            mem[AW'(wr_idx)] <= COST_BITS'(wr_data);
        end
        if (rd_en) begin
            q_reg   <= mem[AW'(rd_idx)];
            hit_reg <= rd_ok;
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;

endmodule

[hdl/srce_checker.sv]
// port level checks for swapped_route_cost_evaluator, attached by bind
// depends on srce_pkg
module srce_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [srce_pkg::ACC_W-1:0]   m_total_cost,
    input logic                         m_position_error
);

    // no result word right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_cost)
            && $stable(m_position_error))
        else $error("stalled result changed");

    // an error word carries zero cost
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_position_error |-> m_total_cost == '0)
        else $error("error word with nonzero cost");

endmodule

bind swapped_route_cost_evaluator srce_checker u_srce_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_total_cost     (m_total_cost),
    .m_position_error (m_position_error)
);
